@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/core/tlnef_pkg.sv @@
// ----------------------------------------------------------------------------
// tlnef_pkg
// Constants and types for the text line-number and escape filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlnef_pkg;

  // Default width of the line number field, in decimal digits
  localparam int unsigned NumberDigitsDef = 6;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 3;
  typedef enum logic [CfgAddrW-1:0] {
    CfgNumberNonblank = 3'd0,
    CfgNumberAll      = 3'd1,
    CfgSqueezeBlank   = 3'd2,
    CfgShowEnds       = 3'd3,
    CfgShowTabs       = 3'd4,
    CfgShowNonprint   = 3'd5
  } cfg_idx_e;

  // Character codes
  localparam logic [7:0] ChTab    = 8'd9;
  localparam logic [7:0] ChLf     = 8'd10;
  localparam logic [7:0] ChSpace  = 8'd32;
  localparam logic [7:0] ChDollar = 8'd36;
  localparam logic [7:0] ChZero   = 8'd48;
  localparam logic [7:0] ChQuest  = 8'd63;
  localparam logic [7:0] ChCaretI = 8'd73;
  localparam logic [7:0] ChCaret  = 8'd94;
  localparam logic [7:0] ChDel    = 8'd127;
  localparam logic [7:0] CtrlTop  = 8'd32;   // first printable code
  localparam logic [7:0] CaretOff = 8'd64;   // control code to caret letter

endpackage

@@ rtl/core/text_line_number_and_escape_filter.sv @@
// ----------------------------------------------------------------------------
// Text line-number and escape filter
// Formats a byte stream: optional line numbers, blank-line squeezing, and
// visible line ends, tabs and control bytes.
// ----------------------------------------------------------------------------
// Usage: one text byte per input transfer gives zero to NUMBER_DIGITS+3
// output bytes; the last byte of each run carries run_last_o. An accepted
// byte sits in the input register, is formatted into the run register once
// it is free, and its first output byte is offered on the next cycle. The
// output port moves one byte per cycle unless out_stall_i is set, and that
// port sets the rate: a stream whose bytes each give one output byte runs
// at one input byte per cycle, while a byte that expands to n output bytes
// (line number field, caret escapes, "$" ends) holds the input side until
// its last output byte is taken. Squeezed bytes give no output. The user is
// to make configuration writes only while idle; the block does not enforce it.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module text_line_number_and_escape_filter
  import tlnef_pkg::*;
#(
  parameter int unsigned NUMBER_DIGITS = NumberDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic                cfg_data_i,
  // input byte stream
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_byte_i,
  // formatted output stream
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                run_last_o
);

  localparam int unsigned CntW   = 4 * NUMBER_DIGITS;
  localparam int unsigned RunMax = NUMBER_DIGITS + 3;
  localparam int unsigned LenW   = $clog2(RunMax + 1);

  // Configuration registers
  logic nb_q, all_q, squeeze_q, ends_q, tabs_q, nonprint_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q       <= 1'b0;
      all_q      <= 1'b0;
      squeeze_q  <= 1'b0;
      ends_q     <= 1'b0;
      tabs_q     <= 1'b0;
      nonprint_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgNumberNonblank: nb_q       <= cfg_data_i;
        CfgNumberAll:      all_q      <= cfg_data_i;
        CfgSqueezeBlank:   squeeze_q  <= cfg_data_i;
        CfgShowEnds:       ends_q     <= cfg_data_i;
        CfgShowTabs:       tabs_q     <= cfg_data_i;
        CfgShowNonprint:   nonprint_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic            in_valid_q, in_valid_d;
  logic [7:0]      in_byte_q;
  logic [LenW-1:0] run_left_q, run_left_d;
  logic [7:0]      run_byte_q [RunMax];
  logic            in_xfer, out_xfer, run_free, take;

  assign out_valid_o = (run_left_q != '0);
  assign out_byte_o  = run_byte_q[0];
  assign run_last_o  = (run_left_q == LenW'(1));
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign run_free    = (run_left_q == '0) || (out_xfer && run_last_o);
  assign take        = in_valid_q && run_free;
  assign in_stall_o  = in_valid_q && !take;
  assign in_xfer     = in_valid_i && !in_stall_o;

  // Line state
  logic [CntW-1:0] line_cnt_q, line_cnt_d;
  logic            at_start_q, at_start_d;
  logic            empty_q, empty_d;
  logic [1:0]      blank_run_q, blank_run_d;

  // Input byte classification
  logic [7:0] c;
  logic       is_lf, is_tab;
  assign c      = in_byte_q;
  assign is_lf  = (c == ChLf);
  assign is_tab = (c == ChTab);

  // Blank-line tracking and squeeze decision
  logic       le_next, drop, numbering, early, num_en;
  logic [1:0] br_inc;
  assign le_next   = at_start_q ? is_lf : empty_q;
  assign br_inc    = !(at_start_q && le_next) ? 2'd0 :
                     (blank_run_q == 2'd3) ? 2'd3 : blank_run_q + 2'd1;
  assign drop      = squeeze_q && (br_inc >= 2'd2);
  assign numbering = (all_q || nb_q) && at_start_q;
  assign early     = numbering && le_next && nb_q;
  assign num_en    = numbering && !early;

  // Saturating BCD increment of the line counter
  logic [CntW-1:0] cnt_inc;
  always_comb begin
    logic all_nine;
    logic carry;
    all_nine = 1'b1;
    carry    = 1'b1;
    cnt_inc  = line_cnt_q;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (line_cnt_q[4*i +: 4] != 4'd9) all_nine = 1'b0;
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (line_cnt_q[4*i +: 4] >= 4'd9) begin
          cnt_inc[4*i +: 4] = 4'd0;
        end else begin
          cnt_inc[4*i +: 4] = line_cnt_q[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all_nine) cnt_inc = line_cnt_q;
  end

  // Leading-zero blanking: digit i > 0 is a space while it and all above are zero
  logic [NUMBER_DIGITS-1:0] blank_dig;
  always_comb begin
    logic zero_run;
    zero_run  = 1'b1;
    blank_dig = '0;
    for (int i = NUMBER_DIGITS - 1; i > 0; i--) begin
      zero_run     = zero_run && (line_cnt_q[4*i +: 4] == 4'd0);
      blank_dig[i] = zero_run;
    end
  end

  // Body bytes following the optional number field
  logic [7:0] body0, body1;
  logic       body_two;
  always_comb begin
    body0    = c;
    body1    = ChLf;
    body_two = 1'b0;
    if (early) begin
      body0    = ends_q ? ChDollar : ChLf;
      body_two = ends_q;
    end else if (ends_q && is_lf) begin
      body0    = ChDollar;
      body_two = 1'b1;
    end else if (tabs_q && is_tab) begin
      body0    = ChCaret;
      body1    = ChCaretI;
      body_two = 1'b1;
    end else if (nonprint_q && (c < CtrlTop) && !is_tab && !is_lf) begin
      body0    = ChCaret;
      body1    = c + CaretOff;
      body_two = 1'b1;
    end else if (nonprint_q && (c == ChDel)) begin
      body0    = ChCaret;
      body1    = ChQuest;
      body_two = 1'b1;
    end
  end

  // Assemble the run into fixed slots
  logic [7:0]      new_byte [RunMax];
  logic [LenW-1:0] new_len;
  always_comb begin
    for (int i = 0; i < RunMax; i++) begin
      new_byte[i] = ChSpace;
      if (num_en) begin
        if (i == NUMBER_DIGITS) begin
          new_byte[i] = ChTab;
        end else if (i == NUMBER_DIGITS + 1) begin
          new_byte[i] = body0;
        end else if (i > NUMBER_DIGITS + 1) begin
          new_byte[i] = body1;
        end
      end else if (i == 0) begin
        new_byte[i] = body0;
      end else if (i == 1) begin
        new_byte[i] = body1;
      end
    end
    // number field is printed most significant digit first
    if (num_en) begin
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        new_byte[i] = blank_dig[NUMBER_DIGITS-1-i] ? ChSpace :
                      (ChZero | {4'h0, line_cnt_q[4*(NUMBER_DIGITS-1-i) +: 4]});
      end
    end
    if (drop) begin
      new_len = '0;
    end else begin
      new_len = (num_en ? LenW'(NUMBER_DIGITS + 1) : LenW'(0))
              + (body_two ? LenW'(2) : LenW'(1));
    end
  end

  // Line state update on each formatted byte
  always_comb begin
    at_start_d  = at_start_q;
    empty_d     = empty_q;
    blank_run_d = blank_run_q;
    line_cnt_d  = line_cnt_q;
    if (take) begin
      empty_d = le_next;
      if (squeeze_q) blank_run_d = drop ? 2'd1 : br_inc;
      if (!drop && !early) begin
        if (is_lf) begin
          at_start_d = 1'b1;
          if (!(le_next && nb_q)) line_cnt_d = cnt_inc;
        end else begin
          at_start_d = 1'b0;
          empty_d    = 1'b0;
        end
      end
    end
  end

  // Stage occupancy
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (take) begin
      in_valid_d = 1'b0;
    end
    run_left_d = run_left_q;
    if (take) begin
      run_left_d = new_len;
    end else if (out_xfer) begin
      run_left_d = run_left_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      run_left_q  <= '0;
      line_cnt_q  <= CntW'(1);
      at_start_q  <= 1'b1;
      empty_q     <= 1'b0;
      blank_run_q <= 2'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      run_left_q  <= run_left_d;
      line_cnt_q  <= line_cnt_d;
      at_start_q  <= at_start_d;
      empty_q     <= empty_d;
      blank_run_q <= blank_run_d;
    end
  end

  // Payload registers: input byte and run shift register
  always_ff @(posedge clk_i) begin
    if (in_xfer) in_byte_q <= in_byte_i;
    if (take) begin
      for (int i = 0; i < RunMax; i++) run_byte_q[i] <= new_byte[i];
    end else if (out_xfer) begin
      for (int i = 0; i < RunMax - 1; i++) run_byte_q[i] <= run_byte_q[i+1];
      run_byte_q[RunMax-1] <= ChSpace;
    end
  end

  // Assertions
  `ASSERT_ALWAYS(a_empty_at_start, !empty_q || at_start_q,
                 "empty-line flag set away from line start")
  `ASSERT_ALWAYS(a_blank_run_low, blank_run_q < 2'd2, "blank run count out of bounds")
  `ASSERT_NEXT(a_run_loaded, take && (new_len != '0), out_valid_o,
               "formatted run not offered on output")
  `ASSERT_NEXT(a_run_drained, out_xfer && run_last_o && !take, !out_valid_o,
               "output still valid after last byte of run")

endmodule
